// ===== rtl/clpc_pkg.sv =====
// Package for the calibrated line position centroid block.
// Fixed field widths, register indexes and fixed-point constants.
// No dependencies.
package clpc_pkg;

  // Port field widths
  localparam int unsigned MAX_SENSORS = 8;
  localparam int unsigned READING_W   = 12;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_W       = 48;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned POS_W       = 18;

  // Fixed-point formats
  localparam int unsigned WEIGHT_W    = 20;  // Q4.16
  localparam int unsigned WEIGHT_FRAC = 16;
  localparam int unsigned WEIGHT_INT  = WEIGHT_W - WEIGHT_FRAC;
  localparam int unsigned POS_FRAC    = 8;
  localparam int unsigned SPACING     = 100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_RED_LO   = 3'd0,
    REG_FRONT_RED_HI   = 3'd1,
    REG_FRONT_BROWN_LO = 3'd2,
    REG_FRONT_BROWN_HI = 3'd3,
    REG_BACK_RED_LO    = 3'd4,
    REG_BACK_RED_HI    = 3'd5,
    REG_BACK_BROWN_LO  = 3'd6,
    REG_BACK_BROWN_HI  = 3'd7
  } cfg_reg_e;

  localparam int unsigned REG_COUNT = 8;

endpackage

// ===== rtl/calibrated_line_position_centroid.sv =====
// Top level of the calibrated line position centroid block.
// Uses clpc_pkg. Pipelined dividers for weights and position, registered adder tree.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid_i/in_stall_o | array_select_i, sensor_count_i, reading_*_i
//  out     | out_valid_o/out_stall_i | line_position_o, no_line_o, bad_range_mask_o
//  cfg     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One item per cycle unless a result is stalled. Stages: 1 capture, 20 weight
// divider steps, 1 product, 3 adder tree levels, 1 divider load, 18 position divider
// steps. The latency is set by the two bit-serial restoring divider pipelines.
// Reset clears the valid bits and the calibration registers.
// A stalled result freezes the whole pipeline; in_stall_o follows it.
module calibrated_line_position_centroid #(
  parameter int unsigned SENSORS     = 8,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                array_select_i,
  input  logic [clpc_pkg::COUNT_W-1:0]        sensor_count_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_0_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_1_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_2_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_3_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_4_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_5_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_6_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_7_i,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [clpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [clpc_pkg::CFG_W-1:0]          cfg_data_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [clpc_pkg::POS_W-1:0]          line_position_o,
  output logic                                no_line_o,
  output logic [clpc_pkg::MAX_SENSORS-1:0]    bad_range_mask_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned WW     = clpc_pkg::WEIGHT_W;
  localparam int unsigned MS     = clpc_pkg::MAX_SENSORS;
  localparam int unsigned WS     = WW + $clog2(SENSORS);
  localparam int unsigned MW     = WW + $clog2(50 * SENSORS * (SENSORS + 1) + 1);
  localparam int unsigned PW     = clpc_pkg::POS_W;
  localparam int unsigned PSHIFT = clpc_pkg::POS_W - clpc_pkg::POS_FRAC;

  typedef struct packed {
    logic          act;
    logic          sat;
    logic [SB-1:0] range;
    logic [SB-1:0] rem;
    logic [WW-1:0] num;
  } wlane_t;

  typedef struct packed {
    logic          nl;
    logic [MS-1:0] mask;
    logic [WS-1:0] div;
    logic [WS-1:0] rem;
    logic [PW-1:0] num;
  } dlane_t;

  // one restoring step of the weight divider
  function automatic wlane_t wstep(wlane_t a);
    logic [SB:0] r;
    wlane_t      b;
    b = a;
    r = {a.rem, a.num[WW-1]};
    if (r >= {1'b0, a.range}) begin
      r = r - {1'b0, a.range};
      b.num = {a.num[WW-2:0], 1'b1};
    end else begin
      b.num = {a.num[WW-2:0], 1'b0};
    end
    b.rem = r[SB-1:0];
    return b;
  endfunction

  // one restoring step of the position divider
  function automatic dlane_t dstep(dlane_t a);
    logic [WS:0] r;
    dlane_t      b;
    b = a;
    r = {a.rem, a.num[PW-1]};
    if (r >= {1'b0, a.div}) begin
      r = r - {1'b0, a.div};
      b.num = {a.num[PW-2:0], 1'b1};
    end else begin
      b.num = {a.num[PW-2:0], 1'b0};
    end
    b.rem = r[WS-1:0];
    return b;
  endfunction

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // calibration registers
  logic [clpc_pkg::CFG_W-1:0] cfg_q [clpc_pkg::REG_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < clpc_pkg::REG_COUNT; k++) cfg_q[k] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // calibration set selected by the item
  logic [clpc_pkg::CFG_W-1:0] red_lo, red_hi, brown_lo, brown_hi;
  always_comb begin
    if (array_select_i) begin
      red_lo   = cfg_q[clpc_pkg::REG_BACK_RED_LO];
      red_hi   = cfg_q[clpc_pkg::REG_BACK_RED_HI];
      brown_lo = cfg_q[clpc_pkg::REG_BACK_BROWN_LO];
      brown_hi = cfg_q[clpc_pkg::REG_BACK_BROWN_HI];
    end else begin
      red_lo   = cfg_q[clpc_pkg::REG_FRONT_RED_LO];
      red_hi   = cfg_q[clpc_pkg::REG_FRONT_RED_HI];
      brown_lo = cfg_q[clpc_pkg::REG_FRONT_BROWN_LO];
      brown_hi = cfg_q[clpc_pkg::REG_FRONT_BROWN_HI];
    end
  end

  logic [clpc_pkg::READING_W-1:0] rd_all [MS];
  assign rd_all[0] = reading_0_i;
  assign rd_all[1] = reading_1_i;
  assign rd_all[2] = reading_2_i;
  assign rd_all[3] = reading_3_i;
  assign rd_all[4] = reading_4_i;
  assign rd_all[5] = reading_5_i;
  assign rd_all[6] = reading_6_i;
  assign rd_all[7] = reading_7_i;

  logic [clpc_pkg::COUNT_W-1:0] cnt_sat;
  assign cnt_sat = (sensor_count_i > clpc_pkg::COUNT_W'(SENSORS)) ?
                   clpc_pkg::COUNT_W'(SENSORS) : sensor_count_i;

  // weight divider pipeline: stage 0 is the capture stage
  wlane_t        wl_d [SENSORS];
  logic [MS-1:0] mask_d;
  wlane_t        wl_q [WW+1][SENSORS];
  logic [MS-1:0] wm_q [WW+1];
  logic          wv_q [WW+1];

  for (genvar i = 0; i < MS; i++) begin : g_lane
    if (i < SENSORS) begin : g_used
      logic [63:0]   red_w, brown_w;
      logic [31:0]   rd_ext;
      logic [SB-1:0] rd, red, brown, diff;
      logic          used, bad;
      always_comb begin
        red_w   = {16'b0, (i < 4) ? red_lo : red_hi};
        brown_w = {16'b0, (i < 4) ? brown_lo : brown_hi};
        red     = red_w[(i % 4) * SB +: SB];
        brown   = brown_w[(i % 4) * SB +: SB];
        rd_ext  = {20'b0, rd_all[i]};
        rd      = rd_ext[SB-1:0];
        used    = clpc_pkg::COUNT_W'(i) < cnt_sat;
        bad     = used && (red <= brown);
        diff    = (rd > brown) ? (rd - brown) : '0;
        mask_d[i]     = bad;
        wl_d[i].act   = used && !bad;
        wl_d[i].range = red - brown;
        wl_d[i].sat   = ({{clpc_pkg::WEIGHT_INT{1'b0}}, diff} >=
                         {wl_d[i].range, {clpc_pkg::WEIGHT_INT{1'b0}}});
        wl_d[i].rem   = diff >> clpc_pkg::WEIGHT_INT;
        wl_d[i].num   = {diff[clpc_pkg::WEIGHT_INT-1:0],
                         {clpc_pkg::WEIGHT_FRAC{1'b0}}};
      end
    end else begin : g_pad
      assign mask_d[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= WW; s++) wv_q[s] <= 1'b0;
    end else if (adv) begin
      wv_q[0] <= in_valid_i;
      for (int s = 1; s <= WW; s++) wv_q[s] <= wv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wl_q[0] <= wl_d;
      wm_q[0] <= mask_d;
      for (int s = 1; s <= WW; s++) begin
        wm_q[s] <= wm_q[s-1];
        for (int i = 0; i < SENSORS; i++) wl_q[s][i] <= wstep(wl_q[s-1][i]);
      end
    end
  end

  // weights and moments per lane
  logic [WW-1:0] w_q [MS];
  logic [MW-1:0] p_q [MS];
  logic [MS-1:0] pm_q;
  logic          pv_q;

  for (genvar i = 0; i < MS; i++) begin : g_prod
    if (i < SENSORS) begin : g_used
      localparam int unsigned LANE_K = clpc_pkg::SPACING * (i + 1);
      logic [WW-1:0] w;
      wlane_t        last;
      always_comb begin
        last = wl_q[WW][i];
        w = !last.act ? '0 : (last.sat ? '1 : last.num);
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          w_q[i] <= w;
          p_q[i] <= MW'(w) * MW'(LANE_K);
        end
      end
    end else begin : g_pad
      assign w_q[i] = '0;
      assign p_q[i] = '0;
    end
  end

  // registered adder tree over eight lanes
  logic [WS-1:0] tw1_q [4];
  logic [MW-1:0] tp1_q [4];
  logic [WS-1:0] tw2_q [2];
  logic [MW-1:0] tp2_q [2];
  logic [WS-1:0] sw_q;
  logic [MW-1:0] sp_q;
  logic [MS-1:0] tm1_q, tm2_q, tm3_q;
  logic          tv1_q, tv2_q, tv3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      tv1_q <= 1'b0;
      tv2_q <= 1'b0;
      tv3_q <= 1'b0;
    end else if (adv) begin
      pv_q  <= wv_q[WW];
      tv1_q <= pv_q;
      tv2_q <= tv1_q;
      tv3_q <= tv2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm_q <= wm_q[WW];
      for (int k = 0; k < 4; k++) begin
        tw1_q[k] <= WS'(w_q[2*k]) + WS'(w_q[2*k+1]);
        tp1_q[k] <= p_q[2*k] + p_q[2*k+1];
      end
      for (int k = 0; k < 2; k++) begin
        tw2_q[k] <= tw1_q[2*k] + tw1_q[2*k+1];
        tp2_q[k] <= tp1_q[2*k] + tp1_q[2*k+1];
      end
      sw_q  <= tw2_q[0] + tw2_q[1];
      sp_q  <= tp2_q[0] + tp2_q[1];
      tm1_q <= pm_q;
      tm2_q <= tm1_q;
      tm3_q <= tm2_q;
    end
  end

  // position divider: moment * 256 / weight sum
  dlane_t dl_d;
  always_comb begin
    dl_d.nl   = (sw_q == '0);
    dl_d.mask = tm3_q;
    dl_d.div  = sw_q;
    dl_d.rem  = WS'(sp_q >> PSHIFT);
    dl_d.num  = {sp_q[PSHIFT-1:0], {clpc_pkg::POS_FRAC{1'b0}}};
  end

  dlane_t dl_q [PW+1];
  logic   dv_q [PW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= PW; s++) dv_q[s] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= tv3_q;
      for (int s = 1; s <= PW; s++) dv_q[s] <= dv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= dl_d;
      for (int s = 1; s <= PW; s++) dl_q[s] <= dstep(dl_q[s-1]);
    end
  end

  // result
  assign out_valid_o      = dv_q[PW];
  assign no_line_o        = dl_q[PW].nl;
  assign line_position_o  = dl_q[PW].nl ? '0 : dl_q[PW].num;
  assign bad_range_mask_o = dl_q[PW].mask;

`ifndef SYNTHESIS
  // the divider remainder stays below the weight sum
  a_pos_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[PW] && !dl_q[PW].nl |-> dl_q[PW].rem < dl_q[PW].div)
    else $error("position divider remainder out of range");

  // weight divider starts with a remainder below the range
  a_w_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wv_q[0] && wl_q[0][0].act && !wl_q[0][0].sat |-> wl_q[0][0].rem < wl_q[0][0].range)
    else $error("weight divider start remainder out of range");

  // zero weight sum and zero moment go together
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv3_q |-> ((sw_q == '0) == (sp_q == '0)))
    else $error("weight sum and moment disagree");
`endif

endmodule

// ===== tb/centroid_checker.sv =====
// Checker for the calibrated line position centroid block.
// Watches the item and result channels, predicts each result and compares it.
// Depends on clpc_pkg.
module centroid_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                array_select_i,
  input  logic [clpc_pkg::COUNT_W-1:0]        sensor_count_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_0_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_1_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_2_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_3_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_4_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_5_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_6_i,
  input  logic [clpc_pkg::READING_W-1:0]      reading_7_i,
  input  logic                                cfg_we_i,
  input  logic [clpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [clpc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [clpc_pkg::POS_W-1:0]          line_position_i,
  input  logic                                no_line_i,
  input  logic [clpc_pkg::MAX_SENSORS-1:0]    bad_range_mask_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [clpc_pkg::POS_W-1:0]       position;
    logic                             no_line;
    logic [clpc_pkg::MAX_SENSORS-1:0] bad_mask;
  } centroid_t;

  logic [clpc_pkg::CFG_W-1:0] levels_q [clpc_pkg::REG_COUNT];
  centroid_t                  centroid_q [$];

  // Level of one sensor from the register pair starting at base
  function automatic logic [clpc_pkg::READING_W-1:0] sensor_level(int unsigned base,
                                                                  int unsigned idx);
    logic [clpc_pkg::CFG_W-1:0] word;
    word = levels_q[base + idx / 4];
    return word[(idx % 4) * clpc_pkg::READING_W +: clpc_pkg::READING_W];
  endfunction

  function automatic centroid_t frame_centroid(
      logic sel, logic [clpc_pkg::COUNT_W-1:0] cnt,
      logic [clpc_pkg::READING_W-1:0] rd [clpc_pkg::MAX_SENSORS]);
    int unsigned      red_base, n;
    logic [63:0]      wsum, moment, w, diff, range;
    logic [clpc_pkg::READING_W-1:0] red, brown;
    centroid_t        res;
    red_base = sel ? clpc_pkg::REG_BACK_RED_LO : clpc_pkg::REG_FRONT_RED_LO;
    n = (cnt > clpc_pkg::MAX_SENSORS) ? clpc_pkg::MAX_SENSORS : cnt;
    wsum = 0;
    moment = 0;
    res = '0;
    for (int unsigned i = 0; i < n; i++) begin
      red = sensor_level(red_base, i);
      brown = sensor_level(red_base + 2, i);
      w = 0;
      if (red <= brown) begin
        res.bad_mask[i] = 1'b1;
      end else begin
        range = red - brown;
        diff = (rd[i] > brown) ? rd[i] - brown : 0;
        w = (diff << clpc_pkg::WEIGHT_FRAC) / range;
        if (w > 64'hFFFFF) w = 64'hFFFFF;
      end
      wsum += w;
      moment += clpc_pkg::SPACING * (i + 1) * w;
    end
    res.no_line = (wsum == 0);
    if (wsum != 0) res.position = clpc_pkg::POS_W'((moment << clpc_pkg::POS_FRAC) / wsum);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [clpc_pkg::READING_W-1:0] rd [clpc_pkg::MAX_SENSORS];
    centroid_t want;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      for (int k = 0; k < clpc_pkg::REG_COUNT; k++) levels_q[k] <= '0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i && cfg_index_i < clpc_pkg::REG_COUNT) levels_q[cfg_index_i] <= cfg_data_i;
      // Predict on each accepted item
      if (in_valid_i && !in_stall_i) begin
        rd = '{reading_0_i, reading_1_i, reading_2_i, reading_3_i,
               reading_4_i, reading_5_i, reading_6_i, reading_7_i};
        centroid_q.push_back(frame_centroid(array_select_i, sensor_count_i, rd));
      end
      // Compare each accepted result
      if (out_valid_i && !out_stall_i) begin
        if (centroid_q.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          want = centroid_q.pop_front();
          if (want.position !== line_position_i) begin
            $error("line_position: expected %0d, got %0d", want.position, line_position_i);
            errs++;
          end
          if (want.no_line !== no_line_i) begin
            $error("no_line: expected %0d, got %0d", want.no_line, no_line_i);
            errs++;
          end
          if (want.bad_mask !== bad_range_mask_i) begin
            $error("bad_range_mask: expected %h, got %h", want.bad_mask, bad_range_mask_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= centroid_q.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the calibrated line position centroid testbench: stimulus and verdict.
// Depends on clpc_pkg, centroid_checker and the block itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 44;
  localparam int WATCHDOG   = 2000;
  localparam int RAND_ITEMS = 1900;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, array_select;
  logic [clpc_pkg::COUNT_W-1:0]   sensor_count;
  logic [clpc_pkg::READING_W-1:0] reading [clpc_pkg::MAX_SENSORS];
  logic cfg_we;
  logic [clpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [clpc_pkg::CFG_W-1:0]     cfg_data;
  logic out_valid, out_stall, no_line;
  logic [clpc_pkg::POS_W-1:0] line_position;
  logic [clpc_pkg::MAX_SENSORS-1:0] bad_mask;
  int fail_count, pending;
  int quiet_cycles = 0;
  bit calm;

  calibrated_line_position_centroid u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .array_select_i(array_select), .sensor_count_i(sensor_count),
    .reading_0_i(reading[0]), .reading_1_i(reading[1]), .reading_2_i(reading[2]),
    .reading_3_i(reading[3]), .reading_4_i(reading[4]), .reading_5_i(reading[5]),
    .reading_6_i(reading[6]), .reading_7_i(reading[7]),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .line_position_o(line_position), .no_line_o(no_line), .bad_range_mask_o(bad_mask)
  );

  centroid_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .array_select_i(array_select), .sensor_count_i(sensor_count),
    .reading_0_i(reading[0]), .reading_1_i(reading[1]), .reading_2_i(reading[2]),
    .reading_3_i(reading[3]), .reading_4_i(reading[4]), .reading_5_i(reading[5]),
    .reading_6_i(reading[6]), .reading_7_i(reading[7]),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .line_position_i(line_position), .no_line_i(no_line), .bad_range_mask_i(bad_mask),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side stalls in bursts, none once calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("calibrated_line_position_centroid test failed");
      $finish;
    end
  end

  // One register write; the caller drops the enable
  task automatic write_level(clpc_pkg::cfg_reg_e idx, logic [clpc_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
  endtask

  // Modes 0-3 fixed levels; else random: red mostly > brown, some <= brown
  task automatic load_levels(int mode);
    logic [clpc_pkg::READING_W-1:0] red, brown;
    logic [clpc_pkg::CFG_W-1:0] words [clpc_pkg::REG_COUNT];
    for (int k = 0; k < clpc_pkg::REG_COUNT; k++) words[k] = '0;
    for (int a = 0; a < 2; a++) begin
      for (int s = 0; s < clpc_pkg::MAX_SENSORS; s++) begin
        case (mode)
          0: begin red = '0; brown = '0; end
          1: begin red = '1; brown = '0; end
          2: begin red = 12'd1; brown = '0; end
          3: begin red = '0; brown = '1; end
          default: begin
            brown = clpc_pkg::READING_W'($urandom_range(0, 2000));
            red = ($urandom_range(0, 7) == 0) ?
                  clpc_pkg::READING_W'($urandom_range(0, brown)) :
                  clpc_pkg::READING_W'($urandom_range(brown + 1, 4095));
          end
        endcase
        words[a * 4 + s / 4][(s % 4) * clpc_pkg::READING_W +: clpc_pkg::READING_W] = red;
        words[a * 4 + 2 + s / 4][(s % 4) * clpc_pkg::READING_W +: clpc_pkg::READING_W] =
          brown;
      end
    end
    for (int k = 0; k < clpc_pkg::REG_COUNT; k++)
      write_level(clpc_pkg::cfg_reg_e'(k), words[k]);
    cfg_we <= 1'b0;
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Present one frame and hold it until accepted
  task automatic send_frame(logic sel, logic [clpc_pkg::COUNT_W-1:0] cnt, int style);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    array_select <= sel;
    sensor_count <= cnt;
    for (int s = 0; s < clpc_pkg::MAX_SENSORS; s++)
      case (style)
        0: reading[s] <= '0;
        1: reading[s] <= '1;
        default: reading[s] <= clpc_pkg::READING_W'($urandom_range(0, 4095));
      endcase
    do @(posedge clk_i); while (in_stall);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0; array_select = 1'b0; sensor_count = '0;
    for (int s = 0; s < clpc_pkg::MAX_SENSORS; s++) reading[s] = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset levels (all ranges bad), then extremes of calibration
    send_frame(1'b0, 4'd8, 1);
    send_frame(1'b1, 4'd0, 2);
    for (int mode = 1; mode < 4; mode++) begin
      wait_drained();
      load_levels(mode);
      send_frame(1'b0, 4'd8, 1);
      send_frame(1'b1, 4'd8, 0);
      send_frame(1'b0, 4'd15, 2);
      send_frame(1'b1, 4'd1, 2);
      send_frame(1'b0, 4'd9, 1);
    end
    wait_drained();
    load_levels(4);
    send_frame(1'b0, 4'd0, 1);
    send_frame(1'b1, 4'd8, 0);

    // Random frames over several calibration sets
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 400 == 399) begin
        wait_drained();
        load_levels((n == 799) ? 1 : 4);
      end
      if (n == RAND_ITEMS - 300) calm = 1'b1;
      send_frame(1'($urandom_range(0, 1)),
                 clpc_pkg::COUNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                : $urandom_range(1, 8)),
                 ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : 2);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("calibrated_line_position_centroid test passed");
    end else begin
      $display("calibrated_line_position_centroid test failed");
    end
    $finish;
  end
endmodule
